[design/bavg_pkg.sv]
package bavg_pkg;

    localparam int SAMPLES_PER_AVERAGE = 8;

    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int SUM_W    = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);
    localparam int CNT_W    = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CURVE_POINTS = 11;
    localparam int SEG_W        = 4;
    localparam int SPAN_W       = 10;
    localparam int NUM_W        = 13;
    localparam int QUO_W        = 4;

    // avg * 1200 * 122 / 1024, then / 22, then * 4000 / 3873
    localparam logic [17:0] MV_SCALE    = 18'(1200 * 122);
    localparam int          P1_W        = 28;
    localparam int          P2_W        = 36;
    localparam int          P3_W        = 25;
    localparam int          P4_W        = 51;
    localparam int          SHIFT_22    = 22;
    localparam int          SHIFT_3873  = 37;
    localparam logic [17:0] RECIP_22    =
        18'(((64'd1 << SHIFT_22) + 64'd21) / 64'd22);
    localparam logic [25:0] RECIP_3873  =
        26'(((64'd1 << SHIFT_3873) + 64'd3872) / 64'd3873);
    localparam logic [11:0] CORR_MUL    = 12'd4000;

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd2900, 13'd3650, 13'd3700, 13'd3740, 13'd3760, 13'd3795,
        13'd3840, 13'd3910, 13'd3980, 13'd4070, 13'd4150
    };

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic             valid;
        logic [AVG_W-1:0] avg;
    } avg_item_t;

endpackage

[design/bavg_front.sv]
module bavg_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bavg_pkg::SAMPLE_W-1:0]   s_sample,
    output bavg_pkg::avg_item_t             push,
    input  logic                            push_ready
);

    logic [bavg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [bavg_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [bavg_pkg::SUM_W-1:0] sum_total;
    logic                       last;
    logic                       acc;

    assign last      = (cnt_reg == bavg_pkg::CNT_W'(bavg_pkg::SAMPLES_PER_AVERAGE - 1));
    assign s_tready  = !last || push_ready;
    assign acc       = s_tvalid && s_tready;
    assign sum_total = sum_reg + bavg_pkg::SUM_W'(s_sample);

    assign push.valid = acc && last;
    assign push.avg   = bavg_pkg::AVG_W'(sum_total / bavg_pkg::SAMPLES_PER_AVERAGE);

    always_comb begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (acc) begin
            if (last) begin
                cnt_next = '0;
                sum_next = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

endmodule

[design/bavg_queue.sv]
module bavg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  bavg_pkg::avg_item_t push,
    output logic                push_ready,
    output bavg_pkg::avg_item_t head,
    input  logic                pop
);

    logic [bavg_pkg::AVG_W-1:0]  mem_reg [bavg_pkg::QUEUE_DEPTH];
    logic [bavg_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bavg_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bavg_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (cnt_reg != bavg_pkg::QCNT_W'(bavg_pkg::QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.avg   = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == bavg_pkg::QPTR_W'(bavg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == bavg_pkg::QPTR_W'(bavg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.avg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/bavg_back.sv]
module bavg_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bavg_pkg::avg_item_t           head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bavg_pkg::MV_W-1:0]     m_voltage_mv,
    output logic [bavg_pkg::PCT_W-1:0]    m_percent
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL_B = 7'b0000010,
        ST_MUL_C = 7'b0000100,
        ST_MUL_D = 7'b0001000,
        ST_SEG   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [bavg_pkg::P1_W-1:0]       p1_reg, p1_next;
    logic [bavg_pkg::P2_W-1:0]       p2_reg, p2_next;
    logic [bavg_pkg::P3_W-1:0]       p3_reg, p3_next;
    logic [bavg_pkg::P4_W-1:0]       p4_reg, p4_next;
    logic [bavg_pkg::MV_W-1:0]       mv_reg, mv_next;
    logic [bavg_pkg::PCT_W-1:0]      base_reg, base_next;
    logic [bavg_pkg::NUM_W-1:0]      rem_reg, rem_next;
    logic [bavg_pkg::SPAN_W-1:0]     span_reg, span_next;
    logic [bavg_pkg::QUO_W-1:0]      quo_reg, quo_next;
    logic [1:0]                      bit_reg, bit_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bavg_pkg::MV_W-1:0]       out_mv_reg, out_mv_next;
    logic [bavg_pkg::PCT_W-1:0]      out_pct_reg, out_pct_next;

    logic [bavg_pkg::MV_W-1:0]       raw_mv;
    logic [bavg_pkg::MV_W-1:0]       mv_calc;
    logic [bavg_pkg::SEG_W-1:0]      seg;
    logic [bavg_pkg::MV_W-1:0]       diff;
    logic [bavg_pkg::MV_W-1:0]       span_full;
    logic [bavg_pkg::NUM_W-1:0]      trial;
    logic                            out_free;

    assign raw_mv   = p2_reg[bavg_pkg::SHIFT_22 + bavg_pkg::MV_W - 1:bavg_pkg::SHIFT_22];
    assign mv_calc  = p4_reg[bavg_pkg::SHIFT_3873 + bavg_pkg::MV_W - 1:bavg_pkg::SHIFT_3873];
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign trial    = bavg_pkg::NUM_W'(span_reg) << bit_reg;

    // first curve point above the voltage
    always_comb begin
        seg = bavg_pkg::SEG_W'(bavg_pkg::CURVE_POINTS - 1);
        for (int i = bavg_pkg::CURVE_POINTS - 1; i >= 1; i--) begin
            if (mv_calc < bavg_pkg::CURVE_MV[i]) begin
                seg = bavg_pkg::SEG_W'(i);
            end
        end
    end

    assign diff      = bavg_pkg::CURVE_MV[seg] - mv_calc;
    assign span_full = bavg_pkg::CURVE_MV[seg] - bavg_pkg::CURVE_MV[seg - 1'b1];

    always_comb begin
        state_next     = state_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        p4_next        = p4_reg;
        mv_next        = mv_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        out_mv_next    = out_mv_reg;
        out_pct_next   = out_pct_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    p1_next    = bavg_pkg::P1_W'(head.avg) * bavg_pkg::P1_W'(bavg_pkg::MV_SCALE);
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                p2_next    = bavg_pkg::P2_W'(p1_reg[bavg_pkg::P1_W-1:10]) *
                             bavg_pkg::P2_W'(bavg_pkg::RECIP_22);
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                p3_next    = bavg_pkg::P3_W'(raw_mv) * bavg_pkg::P3_W'(bavg_pkg::CORR_MUL);
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                p4_next    = bavg_pkg::P4_W'(p3_reg) * bavg_pkg::P4_W'(bavg_pkg::RECIP_3873);
                state_next = ST_SEG;
            end
            ST_SEG: begin
                mv_next  = mv_calc;
                quo_next = '0;
                bit_next = 2'd3;
                if (mv_calc <= bavg_pkg::CURVE_MV[0]) begin
                    base_next = '0;
                    rem_next  = '0;
                    span_next = bavg_pkg::SPAN_W'(1);
                end else if (mv_calc >= bavg_pkg::CURVE_MV[bavg_pkg::CURVE_POINTS - 1]) begin
                    base_next = bavg_pkg::PCT_FULL;
                    rem_next  = '0;
                    span_next = bavg_pkg::SPAN_W'(1);
                end else begin
                    base_next = bavg_pkg::PCT_W'({seg, 3'b000}) +
                                bavg_pkg::PCT_W'({seg, 1'b0});
                    rem_next  = bavg_pkg::NUM_W'({diff, 3'b000}) +
                                bavg_pkg::NUM_W'({diff, 1'b0});
                    span_next = span_full[bavg_pkg::SPAN_W-1:0];
                end
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_reg >= trial) begin
                    rem_next          = rem_reg - trial;
                    quo_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 2'd0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_mv_next    = mv_reg;
                    out_pct_next   = base_reg - bavg_pkg::PCT_W'(quo_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p3_reg      <= p3_next;
        p4_reg      <= p4_next;
        mv_reg      <= mv_next;
        base_reg    <= base_next;
        rem_reg     <= rem_next;
        span_reg    <= span_next;
        quo_reg     <= quo_next;
        out_mv_reg  <= out_mv_next;
        out_pct_reg <= out_pct_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_voltage_mv = out_mv_reg;
    assign m_percent    = out_pct_reg;

endmodule

[design/battery_adc_average_to_percent.sv]
// Battery level from ADC samples.
// s_ channel: one 10-bit ADC sample per transfer (s_tdata[9:0]).
// m_ channel: one result per block of SAMPLES_PER_AVERAGE samples (8):
//   m_tdata[12:0] corrected voltage in mV, m_tdata[19:13] charge percent.
// Samples are taken one per cycle while s_tready is high. The front end
// sums them; on the last sample of a block the average goes into a
// two-entry queue. The back end converts one average at a time: four
// multiply stages, a curve segment lookup, a four-step restoring divide
// for the percent fraction, and a load of the output register.
// It pops a new average from the queue only when idle, so it finishes one
// conversion before starting the next.
// Synchronous reset (aresetn low) clears the partial sum, the queue and
// the output valid flag; no result is pending after reset.
// If m_tready stays low the result holds, the back end finishes its
// current average and waits, and s_tready drops only when the queue is
// full and the next sample would close a block.
module battery_adc_average_to_percent (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [12:0] voltage_mv, [19:13] percent
);

    bavg_pkg::avg_item_t              push;
    bavg_pkg::avg_item_t              head;
    logic                             push_ready;
    logic                             pop;
    logic [bavg_pkg::MV_W-1:0]        voltage_mv;
    logic [bavg_pkg::PCT_W-1:0]       percent;

    bavg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_sample   (s_tdata[bavg_pkg::SAMPLE_W-1:0]),
        .push       (push),
        .push_ready (push_ready)
    );

    bavg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    bavg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_voltage_mv (voltage_mv),
        .m_percent    (percent)
    );

    assign m_tdata = {4'b0000, percent, voltage_mv};

endmodule

[design/bavg_checker.sv]
module bavg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_low_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:0] <= 13'd2900) |-> (m_tdata[19:13] == 7'd0))
        else $error("percent not zero at or below empty voltage");

    a_high_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:0] >= 13'd4150) |-> (m_tdata[19:13] == 7'd100))
        else $error("percent not full at or above full voltage");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:13] <= 7'd100) && (m_tdata[23:20] == 4'd0))
        else $error("percent out of range or padding set");

endmodule

bind battery_adc_average_to_percent bavg_checker u_bavg_checker (.*);
